// ===== sv/pdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Prime drop filter package
// Sequencer states shared by the prime drop filter.
// ----------------------------------------------------------------------------
package pdf_pkg;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_DIV   = 2'd2,
    ST_EMIT  = 2'd3
  } pdf_state_e;

endpackage
`default_nettype wire

// ===== sv/prime_drop_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Prime drop filter
// Passes on each word whose magnitude is neither one nor prime, in arrival
// order, using trial division by odd divisors with a shared one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
// Sequence: 1, 2 and 3 are dropped at the accept edge, and an even magnitude
// goes through the emit state to the output register once that is free. An
// odd magnitude m goes through a restoring division by each odd divisor d
// from three up while d * d <= m; it is kept at the first exact division and
// dropped once d * d exceeds m. One word is in work at a time; the input
// stalls until its verdict is done. Reset clears the sequencer and out valid.
module prime_drop_filter
  import pdf_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire signed [VALUE_WIDTH-1:0]  value_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] kept_value_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W);
  localparam int SW = W + 2;

  pdf_state_e state_q, state_d;

  logic [W-1:0]  value_q, value_d;
  logic [W-1:0]  mag_q, mag_d;
  logic [W-1:0]  div_q, div_d;
  logic [SW-1:0] sq_q, sq_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  out_value_q, out_value_d;

  logic          accept;
  logic [W-1:0]  in_mag;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_diff;
  logic [W-1:0]  rem_next;
  logic          out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept  = in_valid_i && !in_stall_o;
  assign in_mag  = value_i[W-1] ? (~value_i + W'(1)) : value_i;
  assign rem_sh  = {rem_q, mag_q[cnt_q]};
  assign rem_diff = rem_sh - {1'b0, div_q};
  assign rem_next = rem_diff[W] ? rem_sh[W-1:0] : rem_diff[W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    mag_d       = mag_q;
    div_d       = div_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          value_d = value_i;
          mag_d   = in_mag;
          div_d   = W'(3);
          sq_d    = SW'(9);
          if (in_mag == W'(1) || in_mag == W'(2) || in_mag == W'(3)) begin
            state_d = ST_IDLE;
          end else if (!in_mag[0]) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        rem_d = '0;
        cnt_d = CW'(W - 1);
        if (sq_q > {2'b00, mag_q}) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = rem_next;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          if (rem_next == '0) begin
            state_d = ST_EMIT;
          end else begin
            div_d   = div_q + W'(2);
            sq_d    = sq_q + {div_q, 2'b00} + SW'(4);
            state_d = ST_CHECK;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = value_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    mag_q       <= mag_d;
    div_q       <= div_d;
    sq_q        <= sq_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kept_value_o = out_value_q;

`ifndef SYNTHESIS
  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_EMIT)
    else $error("Output word loaded outside the emit state.");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < div_q)
    else $error("Partial remainder not below the divisor.");

  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK || state_q == ST_DIV) |-> div_q[0] && div_q >= W'(3))
    else $error("Trial divisor is not an odd value of at least three.");
`endif

endmodule
`default_nettype wire
